@@ hdl/nists_pkg.sv @@
`timescale 1ns / 1ps

package nists_pkg;

    // Fixed field widths of the request and result channels
    localparam int IDX_W  = 16;
    localparam int KEY_IN_W = 32;
    localparam int LEN_W  = 17;
    localparam int POS_W  = 17;

    // Table position, wide enough to hold the table length itself
    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_ZERO = t_pos'(0);
    localparam t_pos POS_ONE  = t_pos'(1);
    localparam t_pos POS_TWO  = t_pos'(2);

    // Request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

@@ hdl/nearest_index_sorted_table_search.sv @@
`timescale 1ns / 1ps

// Nearest-index search over a sorted key table.
// Request channel (i_in_valid / o_in_stall): a load request (i_mode = 0) writes
// i_key_value into table entry i_entry_index and gives no result. A query
// request (i_mode = 1) returns the index of the entry nearest i_key_value,
// searching from i_start_index up to the table length.
// Result channel (o_out_valid / i_out_stall): one o_nearest_index per query.
// The user must write the table length register through i_cfg_we / i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// A query runs a binary lower-bound search, one table read and one compare per
// cycle on the single memory read port. A table of fewer than two entries
// answers index 0, as does a flat table (entries 0 and 1 equal), and a start past
// the end answers the last entry. The next request can be taken in the same cycle
// as the result shows. No new request is taken until the query has handed its
// result to the output register; the output register holds while i_out_stall
// is high and the block waits in its final state until that register is free.
// Reset clears the length register, the sequencer and the output valid; table
// contents are undefined until loaded.
module nearest_index_sorted_table_search
    import nists_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [KEY_IN_W-1:0] i_key_value,
    input  logic [IDX_W-1:0]    i_start_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IDX_W-1:0]    o_nearest_index
);

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_E1   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_DA   = 3'd5;
    localparam logic [2:0] S_DB   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [KEY_WIDTH-1:0] r_table [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    logic [2:0]           r_state, n_state;
    logic [LEN_W-1:0]     r_len;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_e0, n_e0;
    logic [KEY_WIDTH-1:0] r_dist, n_dist;
    logic                 r_asc, n_asc;
    t_pos                 r_start, n_start;
    t_pos                 r_n, n_n;
    t_pos                 r_first, n_first;
    t_pos                 r_count, n_count;
    t_pos                 r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;

    logic                 w_take;
    logic                 w_load_we;
    t_pos                 w_n;
    t_pos                 w_req_start;
    t_pos                 w_step;
    t_pos                 w_mid;
    t_pos                 w_rd_pos;
    logic                 w_before;
    logic [KEY_WIDTH-1:0] w_diff;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_idx;

    assign w_take      = i_in_valid && !o_in_stall;
    assign w_load_we   = w_take && (i_mode == MODE_LOAD) && (32'(i_entry_index) < DEPTH_U);
    assign w_req_start = t_pos'(i_start_index);

    // Clamp the length register to the table depth
    assign w_n = (32'(r_len) > DEPTH_U) ? t_pos'(TABLE_DEPTH) : r_len;

    // Probe position of the current search window
    assign w_step = r_count >> 1;
    assign w_mid  = r_first + w_step;

    // Order test and distance on the word just read
    assign w_before = r_asc ? (r_rdata < r_key) : (r_rdata > r_key);
    assign w_diff   = (r_key >= r_rdata) ? (r_key - r_rdata) : (r_rdata - r_key);

    // Write loaded entries
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_table[AW'(i_entry_index)] <= KEY_WIDTH'(i_key_value);
        end
    end

    // Read one entry per cycle, data registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_table[AW'(w_rd_pos)];
    end

    // Sequence the search
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_e0        = r_e0;
        n_dist      = r_dist;
        n_asc       = r_asc;
        n_start     = r_start;
        n_n         = r_n;
        n_first     = r_first;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        w_rd_pos    = POS_ZERO;

        unique case (r_state)
            S_IDLE: begin
                // Entry 0 is read here so it is ready right after acceptance
                if (w_take && (i_mode == MODE_QUERY)) begin
                    n_key   = KEY_WIDTH'(i_key_value);
                    n_start = w_req_start;
                    n_n     = w_n;
                    n_first = w_req_start;
                    n_count = w_n - w_req_start;
                    if (w_n < POS_TWO) begin
                        n_res   = POS_ZERO;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_E1;
                    end
                end
            end
            S_E1: begin
                n_e0     = r_rdata;
                w_rd_pos = POS_ONE;
                n_state  = S_CHK;
            end
            S_CHK: begin
                // Decide the table order from entries 0 and 1
                n_asc = (r_e0 < r_rdata);
                if (r_e0 == r_rdata) begin
                    n_res   = POS_ZERO;
                    n_state = S_OUT;
                end else if (r_start >= r_n) begin
                    n_res   = r_n - POS_ONE;
                    n_state = S_OUT;
                end else begin
                    w_rd_pos = w_mid;
                    n_state  = S_SRCH;
                end
            end
            S_SRCH: begin
                // Narrow the window and issue the next probe
                if (w_before) begin
                    n_first = w_mid + POS_ONE;
                    n_count = r_count - w_step - POS_ONE;
                end else begin
                    n_count = w_step;
                end
                if (n_count == POS_ZERO) begin
                    n_state = S_END;
                end else begin
                    w_rd_pos = n_first + (n_count >> 1);
                end
            end
            S_END: begin
                if (r_first == r_start) begin
                    n_res   = r_start;
                    n_state = S_OUT;
                end else if (r_first >= r_n) begin
                    n_res   = r_n - POS_ONE;
                    n_state = S_OUT;
                end else begin
                    w_rd_pos = r_first - POS_ONE;
                    n_state  = S_DA;
                end
            end
            S_DA: begin
                n_dist   = w_diff;
                w_rd_pos = r_first;
                n_state  = S_DB;
            end
            S_DB: begin
                // Ties go to the later entry
                n_res   = (r_dist < w_diff) ? (r_first - POS_ONE) : r_first;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res[IDX_W-1:0];
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_e0      <= n_e0;
        r_dist    <= n_dist;
        r_asc     <= n_asc;
        r_start   <= n_start;
        r_n       <= n_n;
        r_first   <= n_first;
        r_count   <= n_count;
        r_res     <= n_res;
        r_out_idx <= n_out_idx;
    end

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the final state");

    a_window_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((18'(r_first) + 18'(r_count)) <= 18'(r_n)))
        else $error("search window runs past the table end");

    a_window_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && $past(r_state) == S_SRCH) |-> (r_count < $past(r_count)))
        else $error("search window did not shrink");

    a_result_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_n >= POS_TWO) |-> (r_res < r_n))
        else $error("result index beyond table length");
`endif

endmodule
